// ===== hw/rtl/rccpb_pkg.sv =====
// shared types and constants of the rc control packet builder
package rccpb_pkg;

	localparam int IN_MIN_DEF = -10000;
	localparam int IN_MAX_DEF = 10000;

	localparam int ID_W = 24;
	localparam int CHAN_W = 7;
	localparam int LEN_W = 16;
	localparam int AXIS_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int NUM_HOPS = 4;
	localparam int HOP_IDX_W = 2;
	localparam int NUM_BYTES = 9;

	localparam int FULL_SCALE = 1023;

	localparam logic [LEN_W-1:0] BIND_LENGTH_RST = 16'd750;
	localparam logic [CHAN_W-1:0] BIND_RF_CHANNEL = 7'd80;
	localparam logic [7:0] BIND_MARK = 8'h23;
	localparam logic [AXIS_W-1:0] FLIP_LOW = 10'h100;
	localparam logic [AXIS_W-1:0] FLIP_HIGH = 10'h300;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_TX_ID = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOP_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOP_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOP_C = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOP_D = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BIND_LEN = 3'd5;

	typedef struct packed {
		logic [ID_W-1:0] tx_id;
		logic [NUM_HOPS-1:0][CHAN_W-1:0] hop_chan;
	} cfg_t;

	typedef struct packed {
		logic is_bind;
		logic [CHAN_W-1:0] rf_channel;
	} ctl_t;

	typedef struct packed {
		logic stop;
		logic flip;
		logic headless;
		logic ret;
	} flags_t;

	typedef struct packed {
		logic [NUM_BYTES-1:0][7:0] data;
		logic [7:0] sum;
	} pkt_t;

	// switch is active when strictly positive
	function automatic logic is_positive(input logic signed [15:0] v);
		return !v[15] && (v != 16'sd0);
	endfunction

endpackage

// ===== hw/rtl/rc_control_packet_builder_top.sv =====
// Control packet builder: one 10-byte radio packet per accepted request,
// with its RF channel and a bind marker. A request is taken every cycle
// unless in_stall is high; its packet passes the clamp register, the axis
// multiply register and the output register. The axis scaling multiply is
// the stage that sets the cycle time. The user must write configuration
// through cfg_we / cfg_index / cfg_data while the block is idle (unenforced).
module rc_control_packet_builder_top #(
	parameter int IN_MIN = rccpb_pkg::IN_MIN_DEF,
	parameter int IN_MAX = rccpb_pkg::IN_MAX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rccpb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rccpb_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               start_bind,
	input  logic signed [15:0]                 aileron,
	input  logic signed [15:0]                 elevator,
	input  logic signed [15:0]                 throttle,
	input  logic signed [15:0]                 rudder,
	input  logic signed [15:0]                 flip_switch,
	input  logic signed [15:0]                 headless_switch,
	input  logic signed [15:0]                 return_switch,
	input  logic signed [15:0]                 stop_switch,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [7:0]                         byte_zero,
	output logic [7:0]                         byte_one,
	output logic [7:0]                         byte_two,
	output logic [7:0]                         byte_three,
	output logic [7:0]                         byte_four,
	output logic [7:0]                         byte_five,
	output logic [7:0]                         byte_six,
	output logic [7:0]                         byte_seven,
	output logic [7:0]                         byte_eight,
	output logic [7:0]                         sum_byte,
	output logic [rccpb_pkg::CHAN_W-1:0]       rf_channel,
	output logic                               is_bind
);

	localparam int SPAN = IN_MAX - IN_MIN;
	localparam int SPAN_W = $clog2(SPAN + 1);

	logic ready_out;
	logic ready_s2;
	logic ready_s1;
	logic accept;

	rccpb_pkg::cfg_t cfg;
	rccpb_pkg::ctl_t ctl;
	rccpb_pkg::flags_t flags;

	logic [SPAN_W-1:0] ail_off;
	logic [SPAN_W-1:0] ele_off;
	logic [SPAN_W-1:0] thr_off;
	logic [SPAN_W-1:0] rud_off;

	logic valid_s1;
	rccpb_pkg::ctl_t ctl_s1;
	rccpb_pkg::flags_t flags_s1;
	logic [SPAN_W-1:0] ail_s1;
	logic [SPAN_W-1:0] ele_s1;
	logic [SPAN_W-1:0] thr_s1;
	logic [SPAN_W-1:0] rud_s1;

	logic [rccpb_pkg::AXIS_W-1:0] ail_scaled;
	logic [rccpb_pkg::AXIS_W-1:0] ele_scaled;
	logic [rccpb_pkg::AXIS_W-1:0] thr_scaled;
	logic [rccpb_pkg::AXIS_W-1:0] rud_scaled;

	logic valid_s2;
	rccpb_pkg::ctl_t ctl_s2;
	rccpb_pkg::flags_t flags_s2;
	logic [rccpb_pkg::AXIS_W-1:0] ail_s2;
	logic [rccpb_pkg::AXIS_W-1:0] ele_s2;
	logic [rccpb_pkg::AXIS_W-1:0] thr_s2;
	logic [rccpb_pkg::AXIS_W-1:0] rud_s2;

	rccpb_pkg::pkt_t pkt;
	logic out_valid_q;
	rccpb_pkg::pkt_t pkt_q;
	rccpb_pkg::ctl_t ctl_q;

	// each stage moves when the one after it is empty or moving
	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s2 = !valid_s2 || ready_out;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign accept = in_valid && ready_s1;
	assign in_stall = !ready_s1;

	rccpb_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.start_bind (start_bind),
		.cfg        (cfg),
		.ctl        (ctl)
	);

	assign flags.stop = rccpb_pkg::is_positive(stop_switch);
	assign flags.flip = rccpb_pkg::is_positive(flip_switch);
	assign flags.headless = rccpb_pkg::is_positive(headless_switch);
	assign flags.ret = rccpb_pkg::is_positive(return_switch);

	rccpb_axis_offset #(.IN_MIN(IN_MIN), .IN_MAX(IN_MAX)) u_off_ail (
		.raw (aileron), .offset (ail_off));
	rccpb_axis_offset #(.IN_MIN(IN_MIN), .IN_MAX(IN_MAX)) u_off_ele (
		.raw (elevator), .offset (ele_off));
	rccpb_axis_offset #(.IN_MIN(IN_MIN), .IN_MAX(IN_MAX)) u_off_thr (
		.raw (throttle), .offset (thr_off));
	rccpb_axis_offset #(.IN_MIN(IN_MIN), .IN_MAX(IN_MAX)) u_off_rud (
		.raw (rudder), .offset (rud_off));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl;
			flags_s1 <= flags;
			ail_s1 <= ail_off;
			ele_s1 <= ele_off;
			thr_s1 <= thr_off;
			rud_s1 <= rud_off;
		end
	end

	rccpb_axis_mul #(.IN_MIN(IN_MIN), .IN_MAX(IN_MAX)) u_mul_ail (
		.offset (ail_s1), .scaled (ail_scaled));
	rccpb_axis_mul #(.IN_MIN(IN_MIN), .IN_MAX(IN_MAX)) u_mul_ele (
		.offset (ele_s1), .scaled (ele_scaled));
	rccpb_axis_mul #(.IN_MIN(IN_MIN), .IN_MAX(IN_MAX)) u_mul_thr (
		.offset (thr_s1), .scaled (thr_scaled));
	rccpb_axis_mul #(.IN_MIN(IN_MIN), .IN_MAX(IN_MAX)) u_mul_rud (
		.offset (rud_s1), .scaled (rud_scaled));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			ctl_s2 <= ctl_s1;
			flags_s2 <= flags_s1;
			ail_s2 <= ail_scaled;
			ele_s2 <= ele_scaled;
			thr_s2 <= thr_scaled;
			rud_s2 <= rud_scaled;
		end
	end

	rccpb_packet_asm u_asm (
		.cfg   (cfg),
		.ctl   (ctl_s2),
		.flags (flags_s2),
		.ail_q (ail_s2),
		.ele_q (ele_s2),
		.thr_q (thr_s2),
		.rud_q (rud_s2),
		.pkt   (pkt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_s2) begin
			pkt_q <= pkt;
			ctl_q <= ctl_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign byte_zero = pkt_q.data[0];
	assign byte_one = pkt_q.data[1];
	assign byte_two = pkt_q.data[2];
	assign byte_three = pkt_q.data[3];
	assign byte_four = pkt_q.data[4];
	assign byte_five = pkt_q.data[5];
	assign byte_six = pkt_q.data[6];
	assign byte_seven = pkt_q.data[7];
	assign byte_eight = pkt_q.data[8];
	assign sum_byte = pkt_q.sum;
	assign rf_channel = ctl_q.rf_channel;
	assign is_bind = ctl_q.is_bind;

endmodule

// ===== hw/rtl/rccpb_sequencer.sv =====
// configuration registers and bind / hop sequencing state
module rccpb_sequencer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rccpb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rccpb_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                  accept,
	input  logic                                  start_bind,
	output rccpb_pkg::cfg_t                       cfg,
	output rccpb_pkg::ctl_t                       ctl
);

	logic [rccpb_pkg::ID_W-1:0] tx_id_q;
	logic [rccpb_pkg::NUM_HOPS-1:0][rccpb_pkg::CHAN_W-1:0] hop_chan_q;
	logic [rccpb_pkg::LEN_W-1:0] bind_length_q;
	logic in_data_phase_q;
	logic [rccpb_pkg::LEN_W-1:0] bind_remaining_q;
	logic [rccpb_pkg::HOP_IDX_W-1:0] hop_index_q;

	logic phase_eff;
	logic [rccpb_pkg::LEN_W-1:0] remaining_eff;
	logic [rccpb_pkg::HOP_IDX_W-1:0] hop_eff;

	// start_bind restarts the sequence ahead of this request
	assign phase_eff = start_bind ? 1'b0 : in_data_phase_q;
	assign remaining_eff = start_bind ? bind_length_q : bind_remaining_q;
	assign hop_eff = start_bind ? '0 : hop_index_q;

	assign cfg.tx_id = tx_id_q;
	assign cfg.hop_chan = hop_chan_q;

	assign ctl.is_bind = !phase_eff;
	assign ctl.rf_channel = phase_eff ? hop_chan_q[hop_eff] : rccpb_pkg::BIND_RF_CHANNEL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_id_q <= '0;
			hop_chan_q <= '0;
			bind_length_q <= rccpb_pkg::BIND_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rccpb_pkg::REG_TX_ID: tx_id_q <= cfg_data[rccpb_pkg::ID_W-1:0];
				rccpb_pkg::REG_HOP_A: hop_chan_q[0] <= cfg_data[rccpb_pkg::CHAN_W-1:0];
				rccpb_pkg::REG_HOP_B: hop_chan_q[1] <= cfg_data[rccpb_pkg::CHAN_W-1:0];
				rccpb_pkg::REG_HOP_C: hop_chan_q[2] <= cfg_data[rccpb_pkg::CHAN_W-1:0];
				rccpb_pkg::REG_HOP_D: hop_chan_q[3] <= cfg_data[rccpb_pkg::CHAN_W-1:0];
				rccpb_pkg::REG_BIND_LEN: bind_length_q <= cfg_data[rccpb_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_data_phase_q <= 1'b0;
			bind_remaining_q <= rccpb_pkg::BIND_LENGTH_RST;
			hop_index_q <= '0;
		end else if (accept) begin
			if (!phase_eff) begin
				hop_index_q <= hop_eff;
				if (remaining_eff == '0) begin
					in_data_phase_q <= 1'b1;
					bind_remaining_q <= remaining_eff;
				end else begin
					in_data_phase_q <= 1'b0;
					bind_remaining_q <= remaining_eff - 1'b1;
				end
			end else begin
				hop_index_q <= hop_eff + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/rccpb_axis_offset.sv =====
// clamps one stick value and offsets it to start at zero
module rccpb_axis_offset #(
	parameter int IN_MIN = rccpb_pkg::IN_MIN_DEF,
	parameter int IN_MAX = rccpb_pkg::IN_MAX_DEF,
	localparam int SPAN = IN_MAX - IN_MIN,
	localparam int SPAN_W = $clog2(SPAN + 1)
) (
	input  logic signed [15:0] raw,
	output logic [SPAN_W-1:0]  offset
);

	localparam logic signed [16:0] LO = 17'(IN_MIN);
	localparam logic signed [16:0] HI = 17'(IN_MAX);

	logic signed [16:0] wide;
	logic signed [16:0] clamped;
	logic signed [16:0] diff;

	always_comb begin
		wide = {raw[15], raw};
		if (wide < LO) begin
			clamped = LO;
		end else if (wide > HI) begin
			clamped = HI;
		end else begin
			clamped = wide;
		end
		diff = clamped - LO;
	end

	assign offset = diff[SPAN_W-1:0];

endmodule

// ===== hw/rtl/rccpb_axis_mul.sv =====
// scales an offset axis value to 10 bits by multiplying with a reciprocal
module rccpb_axis_mul #(
	parameter int IN_MIN = rccpb_pkg::IN_MIN_DEF,
	parameter int IN_MAX = rccpb_pkg::IN_MAX_DEF,
	localparam int SPAN = IN_MAX - IN_MIN,
	localparam int SPAN_W = $clog2(SPAN + 1)
) (
	input  logic [SPAN_W-1:0]                offset,
	output logic [rccpb_pkg::AXIS_W-1:0]     scaled
);

	// offset * span < 2^SHIFT keeps the rounded-up reciprocal exact for floor
	localparam int SHIFT = 2 * SPAN_W;
	localparam longint unsigned MULT =
		((longint'(rccpb_pkg::FULL_SCALE) << SHIFT) + longint'(SPAN) - 1) / longint'(SPAN);
	localparam int MULT_W = $clog2(MULT + 1);
	localparam int PROD_W = SPAN_W + MULT_W;

	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(offset) * PROD_W'(MULT);
	assign scaled = prod[SHIFT +: rccpb_pkg::AXIS_W];

endmodule

// ===== hw/rtl/rccpb_packet_asm.sv =====
// assembles the packet bytes and checksum from scaled axes and flags
module rccpb_packet_asm (
	input  rccpb_pkg::cfg_t                     cfg,
	input  rccpb_pkg::ctl_t                     ctl,
	input  rccpb_pkg::flags_t                   flags,
	input  logic [rccpb_pkg::AXIS_W-1:0]        ail_q,
	input  logic [rccpb_pkg::AXIS_W-1:0]        ele_q,
	input  logic [rccpb_pkg::AXIS_W-1:0]        thr_q,
	input  logic [rccpb_pkg::AXIS_W-1:0]        rud_q,
	output rccpb_pkg::pkt_t                     pkt
);

	logic [rccpb_pkg::AXIS_W-1:0] ail;
	logic [rccpb_pkg::AXIS_W-1:0] ele;
	logic [rccpb_pkg::AXIS_W-1:0] rud;
	logic may_flip;
	logic [rccpb_pkg::NUM_BYTES-1:0][7:0] b;
	logic [7:0] sum;

	// full scale minus value is the bitwise complement in 10 bits
	assign ail = ~ail_q;
	assign ele = ~ele_q;
	assign rud = ~rud_q;

	assign may_flip = (ail < rccpb_pkg::FLIP_LOW) || (ail > rccpb_pkg::FLIP_HIGH) ||
		(ele < rccpb_pkg::FLIP_LOW) || (ele > rccpb_pkg::FLIP_HIGH);

	always_comb begin
		b[0] = 8'h00;
		if (ctl.is_bind) begin
			b[1] = cfg.tx_id[23:16];
			b[2] = cfg.tx_id[15:8];
			b[3] = cfg.tx_id[7:0];
			b[4] = {1'b0, cfg.hop_chan[0]};
			b[5] = {1'b0, cfg.hop_chan[1]};
			b[6] = {1'b0, cfg.hop_chan[2]};
			b[7] = {1'b0, cfg.hop_chan[3]};
			b[8] = rccpb_pkg::BIND_MARK;
		end else begin
			b[1] = {2'b00, flags.stop, 2'b00, flags.flip && may_flip, ail[9:8]};
			b[2] = ail[7:0];
			b[3] = {3'b000, flags.headless, 1'b0, flags.ret, ele[9:8]};
			b[4] = ele[7:0];
			b[5] = {6'b000000, thr_q[9:8]};
			b[6] = thr_q[7:0];
			// high rate flag always set
			b[7] = {4'b0000, 1'b1, 1'b0, rud[9:8]};
			b[8] = rud[7:0];
		end
		sum = 8'h00;
		for (int i = 0; i < rccpb_pkg::NUM_BYTES; i++) begin
			sum = sum + b[i];
		end
	end

	assign pkt.data = b;
	assign pkt.sum = sum;

endmodule
